// ===== rtl/decimal_text_to_scaled_int_macros.svh =====
// assertion macros shared by the front, queue and top of the decimal text parser
`ifndef DECIMAL_TEXT_TO_SCALED_INT_MACROS_SVH
`define DECIMAL_TEXT_TO_SCALED_INT_MACROS_SVH

// property checked on every clock, off while reset is low
`define DTSI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent on one clock, consequent on the next
`define DTSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dtsi_pkg.sv =====
// types, codes and the power-of-ten table for the decimal text parser
`timescale 1ns / 1ps

package dtsi_pkg;

    localparam int unsigned VALUE_W = 63;
    localparam int unsigned SCALE_W = 5;
    localparam int unsigned POW10_W = 60;

    localparam logic [SCALE_W-1:0] MAX_SCALE = 5'd18;
    localparam logic [SCALE_W-1:0] DIGITS_SAT = 5'd31;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_SCALE  = 3'd2;
    localparam logic [2:0] ST_FORMAT = 3'd3;
    localparam logic [2:0] ST_NEG    = 3'd4;
    localparam logic [2:0] ST_CHAR   = 3'd5;
    localparam logic [2:0] ST_OVF    = 3'd6;
    localparam logic [2:0] ST_PREC   = 3'd7;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] character;
        logic       no_char;
        logic       last;
    } char_beat_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [2:0]         status;
    } res_beat_t;

    // one finished text handed from the front to the back
    typedef struct packed {
        logic [VALUE_W-1:0] whole;
        logic [VALUE_W-1:0] frac;
        logic [SCALE_W-1:0] frac_digits;
        logic [2:0]         status;
    } job_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } queue_flags_t;

    function automatic logic [POW10_W-1:0] pow10(input logic [SCALE_W-1:0] e);
        logic [POW10_W-1:0] p;
        begin
            case (e)
                5'd0:    p = 60'd1;
                5'd1:    p = 60'd10;
                5'd2:    p = 60'd100;
                5'd3:    p = 60'd1000;
                5'd4:    p = 60'd10000;
                5'd5:    p = 60'd100000;
                5'd6:    p = 60'd1000000;
                5'd7:    p = 60'd10000000;
                5'd8:    p = 60'd100000000;
                5'd9:    p = 60'd1000000000;
                5'd10:   p = 60'd10000000000;
                5'd11:   p = 60'd100000000000;
                5'd12:   p = 60'd1000000000000;
                5'd13:   p = 60'd10000000000000;
                5'd14:   p = 60'd100000000000000;
                5'd15:   p = 60'd1000000000000000;
                5'd16:   p = 60'd10000000000000000;
                5'd17:   p = 60'd100000000000000000;
                5'd18:   p = 60'd1000000000000000000;
                default: p = 60'd0;
            endcase
            return p;
        end
    endfunction

endpackage

// ===== rtl/dtsi_front.sv =====
// front end: per-character accumulate, error latch, job hand-off on last
`timescale 1ns / 1ps
`include "decimal_text_to_scaled_int_macros.svh"

module dtsi_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dtsi_pkg::SCALE_W-1:0]  scale,
    input  logic                          take,
    input  dtsi_pkg::char_beat_t          beat,
    output logic                          push,
    output dtsi_pkg::job_t                job
);

    logic [dtsi_pkg::VALUE_W-1:0] whole_reg, whole_next;
    logic [dtsi_pkg::VALUE_W-1:0] frac_reg, frac_next;
    logic [dtsi_pkg::SCALE_W-1:0] digits_reg, digits_next;
    logic                         seen_reg, seen_next;
    logic                         first_reg, first_next;
    logic                         only_pt_reg, only_pt_next;
    logic [2:0]                   err_reg, err_next;

    logic [7:0]                   c;
    logic                         is_digit;
    logic [3:0]                   digit;
    logic [dtsi_pkg::VALUE_W-1:0] acc_sel;
    logic [dtsi_pkg::VALUE_W+3:0] acc_ext;
    logic [dtsi_pkg::VALUE_W+3:0] acc_times10;
    logic                         acc_ovf;

    assign c        = beat.character;
    assign is_digit = (c >= dtsi_pkg::CH_ZERO) && (c <= dtsi_pkg::CH_NINE);
    assign digit    = c[3:0];
    assign acc_sel  = seen_reg ? frac_reg : whole_reg;
    assign acc_ext  = {4'b0, acc_sel};

    // acc*10 + d as shift-add, overflow when it passes 2^63-1
    assign acc_times10 = (acc_ext << 3) + (acc_ext << 1) + {63'b0, digit};
    assign acc_ovf     = |acc_times10[dtsi_pkg::VALUE_W+3:dtsi_pkg::VALUE_W];

    always_comb
    begin
        whole_next   = whole_reg;
        frac_next    = frac_reg;
        digits_next  = digits_reg;
        seen_next    = seen_reg;
        first_next   = first_reg;
        only_pt_next = only_pt_reg;
        err_next     = err_reg;
        push         = 1'b0;
        job          = '0;

        if (take)
        begin
            if (!beat.no_char)
            begin
                if (err_reg == dtsi_pkg::ST_OK)
                begin
                    if (first_reg && (scale > dtsi_pkg::MAX_SCALE))
                    begin
                        err_next = dtsi_pkg::ST_SCALE;
                    end
                    else
                    begin
                        if (seen_reg && (c == dtsi_pkg::CH_DOT))
                        begin
                            err_next = dtsi_pkg::ST_FORMAT;
                        end
                        else if (first_reg && beat.last && (c == dtsi_pkg::CH_DOT))
                        begin
                            err_next = dtsi_pkg::ST_FORMAT;
                        end
                        else if (c == dtsi_pkg::CH_MINUS)
                        begin
                            err_next = dtsi_pkg::ST_NEG;
                        end
                        else if ((c != dtsi_pkg::CH_DOT) && !is_digit)
                        begin
                            err_next = dtsi_pkg::ST_CHAR;
                        end
                        else if (c == dtsi_pkg::CH_DOT)
                        begin
                            seen_next = 1'b1;
                        end
                        else if (acc_ovf)
                        begin
                            err_next = dtsi_pkg::ST_OVF;
                        end
                        else if (seen_reg)
                        begin
                            frac_next = acc_times10[dtsi_pkg::VALUE_W-1:0];
                            if (digits_reg != dtsi_pkg::DIGITS_SAT)
                            begin
                                digits_next = digits_reg + 5'd1;
                            end
                        end
                        else
                        begin
                            whole_next = acc_times10[dtsi_pkg::VALUE_W-1:0];
                        end
                        only_pt_next = first_reg && (c == dtsi_pkg::CH_DOT);
                    end
                end
                first_next = 1'b0;
            end

            if (beat.last)
            begin
                push            = 1'b1;
                job.whole       = whole_next;
                job.frac        = frac_next;
                job.frac_digits = digits_next;
                if (first_next)
                begin
                    job.status = dtsi_pkg::ST_EMPTY;
                end
                else if (err_next != dtsi_pkg::ST_OK)
                begin
                    job.status = err_next;
                end
                else if (only_pt_next)
                begin
                    job.status = dtsi_pkg::ST_FORMAT;
                end
                else
                begin
                    job.status = dtsi_pkg::ST_OK;
                end

                // next beat opens a new text
                whole_next   = '0;
                frac_next    = '0;
                digits_next  = '0;
                seen_next    = 1'b0;
                first_next   = 1'b1;
                only_pt_next = 1'b0;
                err_next     = dtsi_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whole_reg   <= '0;
            frac_reg    <= '0;
            digits_reg  <= '0;
            seen_reg    <= 1'b0;
            first_reg   <= 1'b1;
            only_pt_reg <= 1'b0;
            err_reg     <= dtsi_pkg::ST_OK;
        end
        else
        begin
            whole_reg   <= whole_next;
            frac_reg    <= frac_next;
            digits_reg  <= digits_next;
            seen_reg    <= seen_next;
            first_reg   <= first_next;
            only_pt_reg <= only_pt_next;
            err_reg     <= err_next;
        end
    end

    `DTSI_ASSERT_NEXT(a_text_cleared, take && beat.last, first_reg && !seen_reg && (err_reg == dtsi_pkg::ST_OK), "text state not cleared after last beat")
    `DTSI_ASSERT_NEXT(a_err_sticky, (err_reg != dtsi_pkg::ST_OK) && !(take && beat.last), $stable(err_reg), "latched error changed mid text")

endmodule

// ===== rtl/dtsi_queue.sv =====
// short job queue between front and back
`timescale 1ns / 1ps
`include "decimal_text_to_scaled_int_macros.svh"

module dtsi_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  dtsi_pkg::job_t         push_job,
    input  logic                   pop,
    output dtsi_pkg::job_t         head_job,
    output dtsi_pkg::queue_flags_t flags
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    dtsi_pkg::job_t   slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_job       = slots_reg[rd_ptr_reg];
    assign flags.full     = (count_reg == FULL_CNT);
    assign flags.nonempty = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DTSI_ASSERT(a_no_push_full, (count_reg == FULL_CNT) |-> !push, "push into full queue")
    `DTSI_ASSERT(a_no_pop_empty, pop |-> (count_reg != '0), "pop from empty queue")

endmodule

// ===== rtl/dtsi_back.sv =====
// back end: final checks, pad and scale multiplies, sum, result register
`timescale 1ns / 1ps

module dtsi_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dtsi_pkg::SCALE_W-1:0]  scale,
    input  logic                          head_valid,
    input  dtsi_pkg::job_t                head_job,
    output logic                          pop,
    output logic                          res_valid,
    input  logic                          res_ready,
    output dtsi_pkg::res_beat_t           res_beat
);

    // partial products of a 63 x 60 multiply, the high-high term only as nonzero
    typedef struct packed {
        logic [63:0] ll;
        logic [59:0] lh;
        logic [62:0] hl;
        logic        hh_nz;
    } prod_t;

    function automatic prod_t partial(input logic [62:0] x, input logic [59:0] m);
        prod_t p;
        begin
            p.ll    = {32'b0, x[31:0]} * {32'b0, m[31:0]};
            p.lh    = {28'b0, x[31:0]} * {32'b0, m[59:32]};
            p.hl    = {31'b0, x[62:32]} * {31'b0, m[31:0]};
            p.hh_nz = (|x[62:32]) && (|m[59:32]);
            return p;
        end
    endfunction

    // {overflow, low 63 bits of product}
    function automatic logic [63:0] combine(input prod_t p);
        logic [63:0] mid_sum;
        logic [95:0] total;
        begin
            mid_sum = {4'b0, p.lh} + {1'b0, p.hl};
            total   = {mid_sum, 32'b0} + {32'b0, p.ll};
            return {p.hh_nz | (|total[95:63]), total[62:0]};
        end
    endfunction

    logic                          en;
    logic                          s1_valid_reg, s2_valid_reg, s3_valid_reg, res_valid_reg;

    logic [2:0]                    s1_status_reg, s1_status_next;
    logic [dtsi_pkg::VALUE_W-1:0]  s1_whole_reg, s1_frac_reg;
    logic [dtsi_pkg::POW10_W-1:0]  s1_mw_reg, s1_mf_reg;
    logic [dtsi_pkg::SCALE_W-1:0]  pad;

    logic [2:0]                    s2_status_reg;
    prod_t                         s2_w_reg, s2_f_reg;

    logic [2:0]                    s3_status_reg;
    logic [dtsi_pkg::VALUE_W-1:0]  s3_w_reg, s3_f_reg;
    logic                          s3_ovf_reg;
    logic [63:0]                   w_comb, f_comb;

    logic [dtsi_pkg::VALUE_W:0]    sum;
    logic [2:0]                    res_status_reg, res_status_next;
    logic [dtsi_pkg::VALUE_W-1:0]  res_value_reg, res_value_next;

    // whole pipeline moves together, held only by the result register
    assign en  = !res_valid_reg || res_ready;
    assign pop = en && head_valid;
    assign pad = scale - head_job.frac_digits;

    always_comb
    begin
        if (head_job.status != dtsi_pkg::ST_OK)
        begin
            s1_status_next = head_job.status;
        end
        else if (scale > dtsi_pkg::MAX_SCALE)
        begin
            s1_status_next = dtsi_pkg::ST_SCALE;
        end
        else if (head_job.frac_digits > scale)
        begin
            s1_status_next = dtsi_pkg::ST_PREC;
        end
        else
        begin
            s1_status_next = dtsi_pkg::ST_OK;
        end
    end

    assign w_comb = combine(s2_w_reg);
    assign f_comb = combine(s2_f_reg);

    assign sum = {1'b0, s3_w_reg} + {1'b0, s3_f_reg};

    always_comb
    begin
        if (s3_status_reg != dtsi_pkg::ST_OK)
        begin
            res_status_next = s3_status_reg;
        end
        else if (s3_ovf_reg || sum[dtsi_pkg::VALUE_W])
        begin
            res_status_next = dtsi_pkg::ST_OVF;
        end
        else
        begin
            res_status_next = dtsi_pkg::ST_OK;
        end
        res_value_next = (res_status_next == dtsi_pkg::ST_OK) ?
                         sum[dtsi_pkg::VALUE_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= head_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            res_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_status_reg  <= s1_status_next;
            s1_whole_reg   <= head_job.whole;
            s1_frac_reg    <= head_job.frac;
            s1_mw_reg      <= dtsi_pkg::pow10(scale);
            s1_mf_reg      <= dtsi_pkg::pow10(pad);

            s2_status_reg  <= s1_status_reg;
            s2_w_reg       <= partial(s1_whole_reg, s1_mw_reg);
            s2_f_reg       <= partial(s1_frac_reg, s1_mf_reg);

            s3_status_reg  <= s2_status_reg;
            s3_w_reg       <= w_comb[62:0];
            s3_f_reg       <= f_comb[62:0];
            s3_ovf_reg     <= w_comb[63] | f_comb[63];

            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
        end
    end

    assign res_valid       = res_valid_reg;
    assign res_beat.value  = res_value_reg;
    assign res_beat.status = res_status_reg;

endmodule

// ===== rtl/decimal_text_to_scaled_int.sv =====
// top level of the ascii decimal to scaled integer parser
//
//  channel | direction | handshake              | beat
//  char    | in        | char_valid/char_ready  | character, no_char, last
//  res     | out       | res_valid/res_ready    | value, status
//  cfg     | in        | cfg_we                 | cfg_wdata = scale
//
// one character beat per cycle while char_ready is high; the front accumulates digits
// a result leaves through the job queue and a 4-stage multiply and sum pipeline
// asynchronous reset clears control state; no clearing pass, ready right after reset
// res_ready low while a result waits freezes the back pipeline; the job queue holds
// QUEUE_DEPTH finished texts, and char_ready drops only while that queue is full
`timescale 1ns / 1ps
`include "decimal_text_to_scaled_int_macros.svh"

module decimal_text_to_scaled_int #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          char_valid,
    output logic                          char_ready,
    input  dtsi_pkg::char_beat_t          char_beat,
    output logic                          res_valid,
    input  logic                          res_ready,
    output dtsi_pkg::res_beat_t           res_beat,
    input  logic                          cfg_we,
    input  logic [dtsi_pkg::SCALE_W-1:0]  cfg_wdata
);

    logic [dtsi_pkg::SCALE_W-1:0] scale_reg;
    logic                         take;
    logic                         push;
    logic                         pop;
    dtsi_pkg::job_t               push_job;
    dtsi_pkg::job_t               head_job;
    dtsi_pkg::queue_flags_t       q_flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= '0;
        end
        else if (cfg_we)
        begin
            scale_reg <= cfg_wdata;
        end
    end

    assign char_ready = !q_flags.full;
    assign take       = char_valid && char_ready;

    dtsi_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .scale (scale_reg),
        .take  (take),
        .beat  (char_beat),
        .push  (push),
        .job   (push_job)
    );

    dtsi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .flags    (q_flags)
    );

    dtsi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .scale      (scale_reg),
        .head_valid (q_flags.nonempty),
        .head_job   (head_job),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_beat   (res_beat)
    );

    `DTSI_ASSERT(a_err_value_zero, (res_valid && (res_beat.status != dtsi_pkg::ST_OK)) |-> (res_beat.value == 63'd0), "error result with nonzero value")

endmodule

// ===== bench/result_check.sv =====
// checker for the decimal text parser: predicts each result beat and compares it
`timescale 1ns / 1ps

module result_check
    import dtsi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    input  logic               char_ready,
    input  char_beat_t         char_beat,
    input  logic               res_valid,
    input  logic               res_ready,
    input  res_beat_t          res_beat,
    input  logic               cfg_we,
    input  logic [SCALE_W-1:0] cfg_wdata,
    output int                 fail_count,
    output int                 outstanding
);

    localparam logic [63:0] VAL_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    logic [SCALE_W-1:0] scale_setting;
    logic [63:0]        whole_part;
    logic [63:0]        frac_part;
    logic [SCALE_W-1:0] frac_count;
    logic               point_seen;
    logic               text_start;
    logic               point_only;
    logic [2:0]         first_error;
    res_beat_t          predicted_numbers[$];
    int                 mismatches;

    function automatic void clear_text();
        whole_part  = '0;
        frac_part   = '0;
        frac_count  = '0;
        point_seen  = 1'b0;
        text_start  = 1'b1;
        first_error = ST_OK;
        point_only  = 1'b0;
    endfunction

    // acc = acc*10 + digit, refused when it would pass the signed 64-bit maximum
    function automatic bit append_digit(inout logic [63:0] acc, input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - CH_ZERO);
        if (acc > VAL_LIMIT / 10) return 1'b0;
        acc = acc * 10;
        if (acc > VAL_LIMIT - d) return 1'b0;
        acc = acc + d;
        return 1'b1;
    endfunction

    function automatic logic [2:0] parse_char(input logic [7:0] c, input logic is_last);
        if (point_seen && c == CH_DOT) return ST_FORMAT;
        if (text_start && is_last && c == CH_DOT) return ST_FORMAT;
        if (c == CH_MINUS) return ST_NEG;
        if (c != CH_DOT && (c < CH_ZERO || c > CH_NINE)) return ST_CHAR;
        if (!point_seen)
        begin
            if (c == CH_DOT)
            begin
                point_seen = 1'b1;
                return ST_OK;
            end
            if (!append_digit(whole_part, c)) return ST_OVF;
        end
        else
        begin
            if (!append_digit(frac_part, c)) return ST_OVF;
            if (frac_count < DIGITS_SAT) frac_count++;
        end
        return ST_OK;
    endfunction

    // pad the fraction to the scale, then whole * 10^scale + fraction
    function automatic logic [2:0] close_text(output logic [VALUE_W-1:0] v);
        logic [63:0] f;
        logic [63:0] mult;
        logic [63:0] scaled;
        v = '0;
        if (scale_setting > MAX_SCALE) return ST_SCALE;
        if (frac_count > scale_setting) return ST_PREC;
        f = frac_part;
        for (int j = frac_count; j < scale_setting; j++)
        begin
            if (f > VAL_LIMIT / 10) return ST_OVF;
            f = f * 10;
        end
        mult = 64'd1;
        for (int j = 0; j < scale_setting; j++) mult = mult * 10;
        if (whole_part > VAL_LIMIT / mult) return ST_OVF;
        scaled = whole_part * mult;
        if (scaled > VAL_LIMIT - f) return ST_OVF;
        v = VALUE_W'(scaled + f);
        return ST_OK;
    endfunction

    function automatic void predict_beat(input char_beat_t b);
        res_beat_t          r;
        logic [VALUE_W-1:0] v;
        logic [2:0]         st;
        if (!b.no_char)
        begin
            // once an error is latched the rest of the text is skipped
            if (first_error == ST_OK)
            begin
                if (text_start && scale_setting > MAX_SCALE)
                begin
                    first_error = ST_SCALE;
                end
                else
                begin
                    first_error = parse_char(b.character, b.last);
                    point_only  = text_start && (b.character == CH_DOT);
                end
            end
            text_start = 1'b0;
        end
        if (b.last)
        begin
            v = '0;
            if (text_start) st = ST_EMPTY;
            else if (first_error != ST_OK) st = first_error;
            else if (point_only) st = ST_FORMAT;
            else st = close_text(v);
            if (st != ST_OK) v = '0;
            r.value  = v;
            r.status = st;
            predicted_numbers.push_back(r);
            clear_text();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_beat_t want;
        if (!rst_n)
        begin
            scale_setting = '0;
            clear_text();
            predicted_numbers.delete();
            mismatches = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (char_valid && char_ready) predict_beat(char_beat);
            if (res_valid && res_ready)
            begin
                if (predicted_numbers.size() == 0)
                begin
                    $error("result beat with no text pending: value %0d status %0d",
                           res_beat.value, res_beat.status);
                    mismatches++;
                end
                else
                begin
                    want = predicted_numbers.pop_front();
                    if (res_beat.value !== want.value)
                    begin
                        $error("value: expected %0d, got %0d", want.value, res_beat.value);
                        mismatches++;
                    end
                    if (res_beat.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, res_beat.status);
                        mismatches++;
                    end
                end
            end
            if (cfg_we) scale_setting = cfg_wdata;
            fail_count  <= mismatches;
            outstanding <= predicted_numbers.size();
        end
    end

endmodule

// ===== bench/tb_decimal_text_to_scaled_int.sv =====
// bench top for the decimal text parser: clock, reset, character stimulus and verdict
`timescale 1ns / 1ps

module tb_decimal_text_to_scaled_int;
    import dtsi_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned SEGMENT_CHARS = 55;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               char_valid = 1'b0;
    logic               char_ready;
    char_beat_t         char_beat  = '0;
    logic               res_valid;
    logic               res_ready  = 1'b0;
    res_beat_t          res_beat;
    logic               cfg_we     = 1'b0;
    logic [SCALE_W-1:0] cfg_wdata  = '0;
    int                 fail_count;
    int                 outstanding;

    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    int unsigned        chars_sent    = 0;
    int unsigned        cycle_count   = 0;
    logic [SCALE_W-1:0] scale_now     = '0;
    logic [7:0]         text_chars[$];

    decimal_text_to_scaled_int uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_beat  (char_beat),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_beat   (res_beat),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    result_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_beat   (char_beat),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_beat    (res_beat),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void add_digit();
        text_chars.push_back(8'(CH_ZERO + $urandom_range(9)));
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) text_chars.push_back(s[i]);
    endfunction

    function automatic void build_random_text();
        string       limit_txt = "9223372036854775807";
        int unsigned kind;
        int unsigned n;
        int unsigned pos;
        bit          split;
        kind = $urandom_range(99);
        if (kind < 50)
        begin
            // plain number, mostly within the scale
            n = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 6);
            repeat (n) add_digit();
            if ($urandom_range(99) < 70)
            begin
                text_chars.push_back(CH_DOT);
                n = ($urandom_range(9) == 0) ? $urandom_range(0, 20)
                  : $urandom_range(0, (scale_now > MAX_SCALE) ? 3 : scale_now + 1);
                repeat (n) add_digit();
            end
        end
        else if (kind < 65)
        begin
            // digits of the signed 64-bit maximum, sometimes split so the scaled sum lands on it
            split = (scale_now <= MAX_SCALE) && ($urandom_range(1) == 1);
            n = split ? 19 - scale_now : $urandom_range(17, 19);
            for (int i = 0; i < (split ? 19 : n); i++)
            begin
                if (split && i == n) text_chars.push_back(CH_DOT);
                text_chars.push_back(limit_txt[i]);
            end
            if ($urandom_range(1))
                text_chars[text_chars.size() - 1] = 8'(CH_ZERO + $urandom_range(9));
        end
        else if (kind < 72)
        begin
            // long zero fraction can drive the digit count to saturation
            text_chars.push_back(CH_ZERO);
            text_chars.push_back(CH_DOT);
            repeat ($urandom_range(15, 35)) text_chars.push_back(CH_ZERO);
            if ($urandom_range(1)) add_digit();
        end
        else if (kind < 87)
        begin
            // good number with one character spoiled
            repeat ($urandom_range(1, 4)) add_digit();
            if ($urandom_range(1))
            begin
                text_chars.push_back(CH_DOT);
                repeat ($urandom_range(0, 3)) add_digit();
            end
            pos = $urandom_range(text_chars.size() - 1);
            case ($urandom_range(2))
                0:       text_chars[pos] = CH_MINUS;
                1:       text_chars[pos] = CH_DOT;
                default: text_chars[pos] = 8'($urandom_range(255));
            endcase
        end
        else if (kind < 96)
        begin
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(3))
                    0:       text_chars.push_back(8'($urandom_range(255)));
                    1:       text_chars.push_back(CH_DOT);
                    2:       text_chars.push_back(CH_MINUS);
                    default: add_digit();
                endcase
            end
        end
        else
        begin
            // empty text, lone point or two points
            repeat ($urandom_range(2)) text_chars.push_back(CH_DOT);
        end
    endfunction

    task automatic send_beat(input char_beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_beat  <= b;
        @(posedge clk);
        while (!char_ready) @(posedge clk);
        if (!b.no_char) chars_sent++;
    endtask

    // sep_end closes the text with a beat that carries no character
    task automatic send_text(input bit sep_end);
        char_beat_t b;
        for (int i = 0; i < text_chars.size(); i++)
        begin
            if ($urandom_range(99) < 4)
            begin
                b.character = 8'($urandom_range(255));
                b.no_char   = 1'b1;
                b.last      = 1'b0;
                send_beat(b);
            end
            b.character = text_chars[i];
            b.no_char   = 1'b0;
            b.last      = (i == text_chars.size() - 1) && !sep_end;
            send_beat(b);
        end
        if (sep_end || text_chars.size() == 0)
        begin
            b.character = 8'($urandom_range(255));
            b.no_char   = 1'b1;
            b.last      = 1'b1;
            send_beat(b);
        end
        text_chars.delete();
    endtask

    task automatic drain_results();
        char_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_scale(input logic [SCALE_W-1:0] s);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        scale_now = s;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int unsigned seg;
        int unsigned seg_start;
        int unsigned scale_plan[12] = '{0, 18, 31, 3, 19, 1, 0, 12, 18, 6, 31, 2};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 14;
        recv_idle_pct = 77;

        // directed texts, first at the reset scale of zero, then at scales 31 and 18
        send_text(1'b1);
        add_text(".");
        send_text(1'b0);
        add_text(".");
        send_text(1'b1);
        add_text("1..");
        send_text(1'b0);
        add_text("-5");
        send_text(1'b0);
        text_chars.push_back(8'hFF);
        send_text(1'b0);
        add_text("3");
        text_chars.push_back(8'h00);
        send_text(1'b0);
        add_text("0.5");
        send_text(1'b0);
        add_text("42");
        send_text(1'b1);
        program_scale(5'd31);
        add_text("7");
        send_text(1'b0);
        program_scale(MAX_SCALE);
        add_text("1.5");
        send_text(1'b0);

        for (seg = 0; seg < 12; seg++)
        begin
            case (seg / 4)
                0:
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 77;
                end
                1:
                begin
                    send_idle_pct = 77;
                    recv_idle_pct = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            program_scale((seg == 3 || seg == 9) ? SCALE_W'($urandom_range(MAX_SCALE))
                                                 : SCALE_W'(scale_plan[seg]));
            seg_start = chars_sent;
            while (chars_sent - seg_start < SEGMENT_CHARS)
            begin
                build_random_text();
                send_text($urandom_range(4) == 0);
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
